>>> hw/rtl/sensor_response_frame_checker_defines.svh
// assertion macros shared by the frame checker modules
// no dependencies; taken in by `include in each asserting file
`ifndef SENSOR_RESPONSE_FRAME_CHECKER_DEFINES_SVH
`define SENSOR_RESPONSE_FRAME_CHECKER_DEFINES_SVH

// property must hold in the same cycle as its trigger
`define SRFC_ASSERT_NOW(label, clk, rst_n, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error("frame checker assertion failed");

// property must hold in the cycle after its trigger
`define SRFC_ASSERT_NEXT(label, clk, rst_n, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("frame checker assertion failed");

`endif

>>> hw/rtl/srfc_pkg.sv
// package for the sensor reply frame checker: widths, constants, codes, types
// no dependencies
package srfc_pkg;

    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 16;
    localparam int COUNT_W  = 4;
    localparam int CFG_IDX_W = 1;

    // byte positions within one reply frame
    localparam logic [COUNT_W-1:0] POS_START_FIRST  = 4'd0;
    localparam logic [COUNT_W-1:0] POS_START_SECOND = 4'd1;
    localparam logic [COUNT_W-1:0] POS_VALUE_HI     = 4'd2;
    localparam logic [COUNT_W-1:0] POS_VALUE_LO     = 4'd3;
    localparam logic [COUNT_W-1:0] POS_SUM_LAST     = 4'd7;
    localparam logic [COUNT_W-1:0] POS_CHECK        = 4'd8;
    localparam logic [COUNT_W-1:0] FRAME_LEN        = 4'd9;
    localparam logic [COUNT_W-1:0] COUNT_SAT        = 4'd10;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 1'b1;
    localparam logic [BYTE_W-1:0] START_FIRST_RST  = 8'hff;
    localparam logic [BYTE_W-1:0] START_SECOND_RST = 8'd134;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_LENGTH  = 2'd1,
        STATUS_CONTENT = 2'd2
    } status_t;

    typedef struct packed {
        logic                 valid;
        logic [VALUE_W-1:0]   value;
        status_t              status;
    } result_t;

endpackage

>>> hw/rtl/srfc_in_if.sv
// input channel: one reply byte per word with its burst end flag
// depends on srfc_pkg
interface srfc_in_if;
    logic                        valid;
    logic                        ready;
    logic [srfc_pkg::BYTE_W-1:0] rx_byte;
    logic                        burst_end;

    modport source (output valid, output rx_byte, output burst_end, input ready);
    modport sink (input valid, input rx_byte, input burst_end, output ready);
endinterface

>>> hw/rtl/srfc_out_if.sv
// output channel: one frame result per word
// depends on srfc_pkg
interface srfc_out_if;
    logic                         valid;
    logic                         ready;
    logic [srfc_pkg::VALUE_W-1:0] co2_value;
    logic [1:0]                   frame_status;

    modport source (output valid, output co2_value, output frame_status, input ready);
    modport sink (input valid, input co2_value, input frame_status, output ready);
endinterface

>>> hw/rtl/srfc_frame_core.sv
// per-byte frame state: count, header match, checksum, held concentration
// depends on srfc_pkg and sensor_response_frame_checker_defines.svh
`include "sensor_response_frame_checker_defines.svh"

module srfc_frame_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [srfc_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        burst_end,
    input  logic [srfc_pkg::BYTE_W-1:0] start_first,
    input  logic [srfc_pkg::BYTE_W-1:0] start_second,
    output srfc_pkg::result_t           result
);

    logic [srfc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [srfc_pkg::BYTE_W-1:0]  sum_reg, sum_next;
    logic                         header_good_reg, header_good_next;
    logic                         checksum_good_reg, checksum_good_next;
    logic [srfc_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [srfc_pkg::BYTE_W-1:0]  check_expect;

    assign check_expect = srfc_pkg::BYTE_W'(~sum_reg + 8'd1);

    always_comb
    begin
        count_next         = count_reg;
        sum_next           = sum_reg;
        header_good_next   = header_good_reg;
        checksum_good_next = checksum_good_reg;
        value_next         = value_reg;
        result.valid       = accept && burst_end;
        result.value       = '0;
        result.status      = srfc_pkg::STATUS_OK;

        if (count_reg == srfc_pkg::POS_START_FIRST)
        begin
            header_good_next = header_good_reg && (rx_byte == start_first);
        end
        else if (count_reg inside {[srfc_pkg::POS_START_SECOND:srfc_pkg::POS_SUM_LAST]})
        begin
            if (count_reg == srfc_pkg::POS_START_SECOND)
            begin
                header_good_next = header_good_reg && (rx_byte == start_second);
            end
            sum_next = sum_reg + rx_byte;
            if (count_reg == srfc_pkg::POS_VALUE_HI)
            begin
                value_next = {rx_byte, value_reg[7:0]};
            end
            else if (count_reg == srfc_pkg::POS_VALUE_LO)
            begin
                value_next = {value_reg[15:8], rx_byte};
            end
        end
        else if (count_reg == srfc_pkg::POS_CHECK)
        begin
            checksum_good_next = (rx_byte == check_expect);
        end

        if (count_reg < srfc_pkg::COUNT_SAT)
        begin
            count_next = count_reg + 4'd1;
        end

        // length is judged before content
        if (count_next != srfc_pkg::FRAME_LEN)
        begin
            result.status = srfc_pkg::STATUS_LENGTH;
        end
        else if (header_good_next && checksum_good_next)
        begin
            result.value = value_next;
        end
        else
        begin
            result.status = srfc_pkg::STATUS_CONTENT;
        end

        // burst end returns the frame state to its reset value
        if (burst_end)
        begin
            count_next         = '0;
            sum_next           = '0;
            header_good_next   = 1'b1;
            checksum_good_next = 1'b0;
            value_next         = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            sum_reg           <= '0;
            header_good_reg   <= 1'b1;
            checksum_good_reg <= 1'b0;
            value_reg         <= '0;
        end
        else if (accept)
        begin
            count_reg         <= count_next;
            sum_reg           <= sum_next;
            header_good_reg   <= header_good_next;
            checksum_good_reg <= checksum_good_next;
            value_reg         <= value_next;
        end
    end

    `SRFC_ASSERT_NOW(a_count_saturates, clk, rst_n, 1'b1,
        count_reg <= srfc_pkg::COUNT_SAT)
    `SRFC_ASSERT_NEXT(a_burst_end_clears_count, clk, rst_n, accept && burst_end,
        count_reg == '0 && sum_reg == '0)
    `SRFC_ASSERT_NEXT(a_burst_end_clears_flags, clk, rst_n, accept && burst_end,
        header_good_reg && !checksum_good_reg)

endmodule

>>> hw/rtl/sensor_response_frame_checker.sv
// top level of the sensor reply frame checker: config registers, output register
// depends on srfc_pkg, srfc_in_if, srfc_out_if, srfc_frame_core and the defines header
`include "sensor_response_frame_checker_defines.svh"

// Takes a gas-sensor reply one byte per word on rx, at up to one byte every
// cycle, and gives one word on result for each byte flagged burst_end: the
// concentration (byte 2 high, byte 3 low) with status ok, or zero with status
// length (burst not exactly nine bytes) or content (byte 0 or 1 differs from
// the configured start values, or byte 8 is not the negated sum of bytes 1
// to 7). Each taken byte updates the frame state; the result is shown on
// result the cycle after its last byte is taken and sits in a single
// output register, so rx stays ready while that register is empty or being
// drained and stalls only when a result waits and result.ready is low. The
// two start values reset to 0xff and 134; the user writes them via cfg_we/
// cfg_index/cfg_data only while no burst runs; the block does not enforce it.
module sensor_response_frame_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    srfc_in_if.sink                     rx,
    srfc_out_if.source                  result,
    input  logic                        cfg_we,
    input  logic [srfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srfc_pkg::BYTE_W-1:0] cfg_data
);

    // configuration registers
    logic [srfc_pkg::BYTE_W-1:0] start_first_reg;
    logic [srfc_pkg::BYTE_W-1:0] start_second_reg;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic [srfc_pkg::VALUE_W-1:0] out_value_reg;
    srfc_pkg::status_t            out_status_reg;

    logic              accept;
    srfc_pkg::result_t frame_result;

    // a byte may enter whenever the output register is free or emptying
    assign rx.ready = !out_valid_reg || result.ready;
    assign accept   = rx.valid && rx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_first_reg  <= srfc_pkg::START_FIRST_RST;
            start_second_reg <= srfc_pkg::START_SECOND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                srfc_pkg::CFG_START_FIRST:  start_first_reg  <= cfg_data;
                srfc_pkg::CFG_START_SECOND: start_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    srfc_frame_core u_frame_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (rx.rx_byte),
        .burst_end    (rx.burst_end),
        .start_first  (start_first_reg),
        .start_second (start_second_reg),
        .result       (frame_result)
    );

    // a new result wins over the drain of the old one in the same cycle
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (frame_result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (frame_result.valid)
        begin
            out_value_reg  <= frame_result.value;
            out_status_reg <= frame_result.status;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.co2_value    = out_value_reg;
    assign result.frame_status = out_status_reg;

    `SRFC_ASSERT_NEXT(a_last_byte_gives_result, clk, rst_n, accept && rx.burst_end,
        out_valid_reg)
    `SRFC_ASSERT_NOW(a_error_value_zero, clk, rst_n,
        out_valid_reg && out_status_reg != srfc_pkg::STATUS_OK, out_value_reg == '0)
    `SRFC_ASSERT_NEXT(a_no_result_without_end, clk, rst_n,
        !out_valid_reg && !(accept && rx.burst_end), !out_valid_reg)

endmodule
